// ===== rtl/i2e_pkg.sv =====
// shared types and constants for the i2c target echo buffer
// no dependencies; used by the controller, datapath and top level
package i2e_pkg;

    typedef enum logic [2:0] {
        MODE_ADDRESSED = 3'd0,
        MODE_READ      = 3'd1,
        MODE_WRITE     = 3'd2,
        MODE_STOP      = 3'd3,
        MODE_ERROR     = 3'd4,
        MODE_FETCH     = 3'd5
    } mode_t;

    typedef logic [1:0] bank_t;

    localparam bank_t RX_BANK_RST  = 2'd0;
    localparam bank_t TX_BANK_RST  = 2'd1;
    localparam bank_t CAP_BANK_RST = 2'd2;

    localparam logic [6:0] OWN_ADDRESS_RST = 7'd40;

    // controller to datapath commands
    typedef struct packed {
        logic exec;
        logic take;
    } cmd_t;

endpackage

// ===== rtl/i2e_event_if.sv =====
// input channel carrying one bus event request
// depends on nothing
interface i2e_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [6:0] bus_address;
    logic [7:0] write_byte;
    logic [4:0] fetch_index;

    modport source (output valid, output mode, output bus_address, output write_byte,
                    output fetch_index, input ready);
    modport sink   (input valid, input mode, input bus_address, input write_byte,
                    input fetch_index, output ready);
endinterface

// ===== rtl/i2e_result_if.sv =====
// output channel carrying one event result request
// depends on nothing; COUNT_W must match the block's count width
interface i2e_result_if #(
    parameter int COUNT_W = 6
);
    logic               valid;
    logic               ready;
    logic               ack;
    logic [7:0]         read_byte;
    logic               byte_driven;
    logic               echo_done;
    logic               capture_pending;
    logic [COUNT_W-1:0] capture_length;

    modport source (output valid, output ack, output read_byte, output byte_driven,
                    output echo_done, output capture_pending, output capture_length,
                    input ready);
    modport sink   (input valid, input ack, input read_byte, input byte_driven,
                    input echo_done, input capture_pending, input capture_length,
                    output ready);
endinterface

// ===== rtl/i2e_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module i2e_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 96
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/i2e_ctrl.sv =====
// handshake controller: accepts one event, holds its result until taken
// depends on i2e_pkg
module i2e_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output i2e_pkg::cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_HOLD
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg     <= ST_HOLD;
                        out_valid_reg <= 1'b1;
                    end
                end
                ST_HOLD:
                begin
                    if (out_ready)
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg     <= ST_IDLE;
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign cmd.exec  = in_valid && (state_reg == ST_IDLE);
    assign cmd.take  = out_valid_reg && out_ready;

endmodule

// ===== rtl/i2e_dpath.sv =====
// datapath: bank pointers, counters, own address, byte ram and result registers
// depends on i2e_pkg and i2e_ram
module i2e_dpath #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  i2e_pkg::cmd_t                     cmd,
    input  logic                              cfg_we,
    input  logic [6:0]                        cfg_wdata,
    input  logic [2:0]                        mode,
    input  logic [6:0]                        bus_address,
    input  logic [7:0]                        write_byte,
    input  logic [4:0]                        fetch_index,
    output logic                              ack,
    output logic [7:0]                        read_byte,
    output logic                              byte_driven,
    output logic                              echo_done,
    output logic                              capture_pending,
    output logic [$clog2(BUFFER_DEPTH+1)-1:0] capture_length
);

    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int PW = $clog2(BUFFER_DEPTH);
    localparam int RAM_DEPTH = 3 * BUFFER_DEPTH;
    localparam int AW = $clog2(RAM_DEPTH);
    localparam int FW = (CW > 5) ? CW : 5;
    localparam logic [CW-1:0] DEPTH_C   = CW'(BUFFER_DEPTH);
    localparam logic [CW-1:0] DEPTH_M1  = CW'(BUFFER_DEPTH - 1);
    localparam logic [CW-1:0] CNT_ONE   = CW'(1);
    localparam logic [AW-1:0] BANK1_OFS = AW'(BUFFER_DEPTH);
    localparam logic [AW-1:0] BANK2_OFS = AW'(2 * BUFFER_DEPTH);

    // state
    logic [6:0]      own_addr_reg;
    i2e_pkg::bank_t  rx_bank_reg, rx_bank_next;
    i2e_pkg::bank_t  tx_bank_reg, tx_bank_next;
    i2e_pkg::bank_t  cap_bank_reg, cap_bank_next;
    logic [CW-1:0]   rx_cnt_reg, rx_cnt_next;
    logic [CW-1:0]   tx_cnt_reg, tx_cnt_next;
    logic [CW-1:0]   tx_pos_reg, tx_pos_next;
    logic [CW-1:0]   cap_cnt_reg, cap_cnt_next;
    logic            pend_reg, pend_next;

    // result
    logic            ack_reg, ack_next;
    logic            drv_reg, drv_next;
    logic            echo_reg, echo_next;
    logic            pend_out_reg;
    logic [CW-1:0]   cap_len_reg;
    logic            rsel_reg;

    // ram port
    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [7:0]      ram_rdata;

    logic [FW-1:0]   fidx_wide;
    logic [FW-1:0]   cap_cnt_wide;
    i2e_pkg::mode_t  ev_mode;

    function automatic logic [AW-1:0] slot(input i2e_pkg::bank_t bank,
                                           input logic [PW-1:0] pos);
        logic [AW-1:0] base;
        unique case (bank)
            2'd1:    base = BANK1_OFS;
            2'd2:    base = BANK2_OFS;
            default: base = '0;
        endcase
        return base + AW'(pos);
    endfunction

    assign ev_mode      = i2e_pkg::mode_t'(mode);
    assign fidx_wide    = FW'(fetch_index);
    assign cap_cnt_wide = FW'(cap_cnt_reg);

    always_comb
    begin
        rx_bank_next  = rx_bank_reg;
        tx_bank_next  = tx_bank_reg;
        cap_bank_next = cap_bank_reg;
        rx_cnt_next   = rx_cnt_reg;
        tx_cnt_next   = tx_cnt_reg;
        tx_pos_next   = tx_pos_reg;
        cap_cnt_next  = cap_cnt_reg;
        pend_next     = pend_reg;
        ack_next      = 1'b0;
        drv_next      = 1'b0;
        echo_next     = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = slot(rx_bank_reg, rx_cnt_reg[PW-1:0]);
        ram_raddr     = slot(tx_bank_reg, tx_pos_reg[PW-1:0]);

        unique case (ev_mode)
            i2e_pkg::MODE_ADDRESSED:
            begin
                ack_next = (bus_address == own_addr_reg);
                // pending received bytes become the transmit message
                if (rx_cnt_reg != '0)
                begin
                    rx_bank_next = tx_bank_reg;
                    tx_bank_next = rx_bank_reg;
                    tx_cnt_next  = rx_cnt_reg;
                    rx_cnt_next  = '0;
                    tx_pos_next  = '0;
                end
            end
            i2e_pkg::MODE_READ:
            begin
                ack_next = 1'b1;
                if (tx_pos_reg < tx_cnt_reg)
                begin
                    ram_re      = 1'b1;
                    tx_pos_next = tx_pos_reg + CNT_ONE;
                    drv_next    = 1'b1;
                end
            end
            i2e_pkg::MODE_WRITE:
            begin
                if (rx_cnt_reg < DEPTH_C)
                begin
                    ram_we      = 1'b1;
                    rx_cnt_next = rx_cnt_reg + CNT_ONE;
                    // the byte that fills the buffer is stored but nacked
                    ack_next    = (rx_cnt_reg < DEPTH_M1);
                end
            end
            i2e_pkg::MODE_STOP:
            begin
                if ((tx_cnt_reg != '0) && (rx_cnt_reg == '0))
                begin
                    cap_bank_next = tx_bank_reg;
                    tx_bank_next  = cap_bank_reg;
                    cap_cnt_next  = tx_cnt_reg;
                    pend_next     = 1'b1;
                    echo_next     = 1'b1;
                end
                tx_cnt_next = '0;
                rx_cnt_next = '0;
                ack_next    = 1'b1;
            end
            i2e_pkg::MODE_FETCH:
            begin
                ack_next  = pend_reg;
                pend_next = 1'b0;
                ram_raddr = slot(cap_bank_reg, fidx_wide[PW-1:0]);
                if (fidx_wide < cap_cnt_wide)
                begin
                    ram_re = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (!cmd.exec)
        begin
            ram_we = 1'b0;
            ram_re = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg <= i2e_pkg::OWN_ADDRESS_RST;
            rx_bank_reg  <= i2e_pkg::RX_BANK_RST;
            tx_bank_reg  <= i2e_pkg::TX_BANK_RST;
            cap_bank_reg <= i2e_pkg::CAP_BANK_RST;
            rx_cnt_reg   <= '0;
            tx_cnt_reg   <= '0;
            tx_pos_reg   <= '0;
            cap_cnt_reg  <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                own_addr_reg <= cfg_wdata;
            end
            if (cmd.exec)
            begin
                rx_bank_reg  <= rx_bank_next;
                tx_bank_reg  <= tx_bank_next;
                cap_bank_reg <= cap_bank_next;
                rx_cnt_reg   <= rx_cnt_next;
                tx_cnt_reg   <= tx_cnt_next;
                tx_pos_reg   <= tx_pos_next;
                cap_cnt_reg  <= cap_cnt_next;
                pend_reg     <= pend_next;
            end
        end
    end

    // result registers hold until the next event is executed; the read select clears once the result is taken
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            ack_reg      <= ack_next;
            drv_reg      <= drv_next;
            echo_reg     <= echo_next;
            pend_out_reg <= pend_reg;
            cap_len_reg  <= cap_cnt_next;
            rsel_reg     <= ram_re;
        end
        else if (cmd.take)
        begin
            rsel_reg <= 1'b0;
        end
    end

    i2e_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (write_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ack             = ack_reg;
    assign read_byte       = rsel_reg ? ram_rdata : 8'd0;
    assign byte_driven     = drv_reg;
    assign echo_done       = echo_reg;
    assign capture_pending = pend_out_reg;
    assign capture_length  = cap_len_reg;

endmodule

// ===== rtl/i2c_target_echo_buffer.sv =====
// Event handler for an I2C target that echoes what the master writes. Each
// request on event_ch is one bus event; exactly one result request follows on
// result_ch. An event is taken and its result is offered in the next cycle; the
// controller holds one result at a time, so the next event is taken only once
// the result has been taken. Received, transmit and capture data live in three
// banks of one byte RAM of 3*BUFFER_DEPTH entries with a registered read;
// messages change role by swapping bank numbers, never by copying. The RAM
// needs no clearing after reset. The user writes own_address through
// cfg_we/cfg_wdata only while idle; the block itself does not enforce this.
// top level; depends on i2e_pkg, i2e_event_if, i2e_result_if, i2e_ctrl, i2e_dpath
module i2c_target_echo_buffer #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    i2e_event_if.sink           event_ch,
    i2e_result_if.source        result_ch,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_wdata
);

    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    i2e_pkg::cmd_t cmd;
    logic [CW-1:0] cap_len;

    i2e_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (event_ch.valid),
        .in_ready  (event_ch.ready),
        .out_valid (result_ch.valid),
        .out_ready (result_ch.ready),
        .cmd       (cmd)
    );

    i2e_dpath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .mode            (event_ch.mode),
        .bus_address     (event_ch.bus_address),
        .write_byte      (event_ch.write_byte),
        .fetch_index     (event_ch.fetch_index),
        .ack             (result_ch.ack),
        .read_byte       (result_ch.read_byte),
        .byte_driven     (result_ch.byte_driven),
        .echo_done       (result_ch.echo_done),
        .capture_pending (result_ch.capture_pending),
        .capture_length  (cap_len)
    );

    assign result_ch.capture_length = cap_len;

endmodule

// ===== tb/i2e_reply_checker.sv =====
`timescale 1ns / 100ps
// reply checker for the i2c target echo buffer: mirrors the three-bank state,
// predicts one reply per accepted bus event and compares it field by field
// depends on i2e_pkg
module i2e_reply_checker #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    input  logic       event_valid,
    input  logic       event_ready,
    input  logic [2:0] event_mode,
    input  logic [6:0] event_bus_address,
    input  logic [7:0] event_write_byte,
    input  logic [4:0] event_fetch_index,
    input  logic       result_valid,
    input  logic       result_ready,
    input  logic       result_ack,
    input  logic [7:0] result_read_byte,
    input  logic       result_byte_driven,
    input  logic       result_echo_done,
    input  logic       result_capture_pending,
    input  logic [5:0] result_capture_length,
    output int         mismatch_count,
    output int         replies_due_count
);
    import i2e_pkg::*;

    typedef struct packed {
        logic       ack;
        logic [7:0] read_byte;
        logic       byte_driven;
        logic       echo_done;
        logic       capture_pending;
        logic [5:0] capture_length;
    } bus_reply_t;

    logic [7:0] bank_bytes [0:3*BUFFER_DEPTH-1];
    bank_t      rx_bank;
    bank_t      tx_bank;
    bank_t      cap_bank;
    logic [5:0] rx_count;
    logic [5:0] tx_count;
    logic [5:0] tx_pos;
    logic [5:0] cap_count;
    logic       capture_flag;
    logic [6:0] own_address;
    bus_reply_t replies_due [$];

    function automatic int byte_slot(bank_t bank, logic [5:0] pos);
        return int'(bank) * BUFFER_DEPTH + int'(pos);
    endfunction

    // applies one bus event to the mirrored state and returns its reply
    function automatic bus_reply_t compute_bus_reply(logic [2:0] mode, logic [6:0] addr,
                                                     logic [7:0] data, logic [4:0] idx);
        bus_reply_t reply;
        bank_t      spare;
        reply = '0;
        reply.capture_pending = capture_flag;
        case (mode)
            MODE_ADDRESSED:
            begin
                reply.ack = (addr == own_address);
                // received bytes turn into the transmit message, matched or not
                if (rx_count != 0)
                begin
                    spare    = tx_bank;
                    tx_bank  = rx_bank;
                    rx_bank  = spare;
                    tx_count = rx_count;
                    rx_count = '0;
                    tx_pos   = '0;
                end
            end
            MODE_READ:
            begin
                reply.ack = 1'b1;
                if (tx_pos < tx_count)
                begin
                    reply.read_byte   = bank_bytes[byte_slot(tx_bank, tx_pos)];
                    reply.byte_driven = 1'b1;
                    tx_pos++;
                end
            end
            MODE_WRITE:
            begin
                if (rx_count < BUFFER_DEPTH)
                begin
                    bank_bytes[byte_slot(rx_bank, rx_count)] = data;
                    rx_count++;
                    // the byte that fills the buffer is kept but nacked
                    reply.ack = (rx_count < BUFFER_DEPTH);
                end
            end
            MODE_STOP:
            begin
                if (tx_count != 0 && rx_count == 0)
                begin
                    spare           = cap_bank;
                    cap_bank        = tx_bank;
                    tx_bank         = spare;
                    cap_count       = tx_count;
                    capture_flag    = 1'b1;
                    reply.echo_done = 1'b1;
                end
                tx_count  = '0;
                rx_count  = '0;
                reply.ack = 1'b1;
            end
            MODE_FETCH:
            begin
                reply.ack = reply.capture_pending;
                if ({1'b0, idx} < cap_count)
                    reply.read_byte = bank_bytes[byte_slot(cap_bank, {1'b0, idx})];
                capture_flag = 1'b0;
            end
            default:
            begin
            end
        endcase
        reply.capture_length = cap_count;
        return reply;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bus_reply_t due;
        if (!rst_n)
        begin
            rx_bank        = RX_BANK_RST;
            tx_bank        = TX_BANK_RST;
            cap_bank       = CAP_BANK_RST;
            rx_count       = '0;
            tx_count       = '0;
            tx_pos         = '0;
            cap_count      = '0;
            capture_flag   = 1'b0;
            own_address    = OWN_ADDRESS_RST;
            mismatch_count = 0;
            replies_due.delete();
        end
        else
        begin
            if (cfg_we)
                own_address = cfg_wdata;
            // replies come after their request is accepted, so compare first
            if (result_valid && result_ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("reply with no bus event waiting for it");
                    mismatch_count++;
                end
                else
                begin
                    due = replies_due.pop_front();
                    check_field("ack", due.ack, result_ack);
                    check_field("read_byte", due.read_byte, result_read_byte);
                    check_field("byte_driven", due.byte_driven, result_byte_driven);
                    check_field("echo_done", due.echo_done, result_echo_done);
                    check_field("capture_pending", due.capture_pending,
                                result_capture_pending);
                    check_field("capture_length", due.capture_length,
                                result_capture_length);
                end
            end
            if (event_valid && event_ready)
                replies_due.push_back(compute_bus_reply(event_mode, event_bus_address,
                                                        event_write_byte, event_fetch_index));
        end
        replies_due_count = replies_due.size();
    end

endmodule

// ===== tb/tb_i2c_target_echo_buffer.sv =====
`timescale 1ns / 100ps
// testbench top for i2c_target_echo_buffer: drives bus event requests and
// own-address writes, paces the reply side and gives the verdict
// depends on i2e_pkg, i2e_event_if, i2e_result_if, i2c_target_echo_buffer and i2e_reply_checker
module tb_i2c_target_echo_buffer;
    import i2e_pkg::*;

    localparam int BUFFER_DEPTH  = 32;
    localparam int RANDOM_EVENTS = 1400;
    localparam int PHASES        = 4;
    localparam int STALL_LIMIT   = 2000;

    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [6:0] cfg_wdata;
    logic       gaps_on;
    logic [6:0] target_address;
    int         counted_events;
    int         mismatch_count;
    int         replies_due_count;

    i2e_event_if                 event_ch ();
    i2e_result_if #(.COUNT_W(6)) result_ch ();

    i2c_target_echo_buffer #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .event_ch (event_ch),
        .result_ch(result_ch),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    i2e_reply_checker #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_checker (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_we                (cfg_we),
        .cfg_wdata             (cfg_wdata),
        .event_valid           (event_ch.valid),
        .event_ready           (event_ch.ready),
        .event_mode            (event_ch.mode),
        .event_bus_address     (event_ch.bus_address),
        .event_write_byte      (event_ch.write_byte),
        .event_fetch_index     (event_ch.fetch_index),
        .result_valid          (result_ch.valid),
        .result_ready          (result_ch.ready),
        .result_ack            (result_ch.ack),
        .result_read_byte      (result_ch.read_byte),
        .result_byte_driven    (result_ch.byte_driven),
        .result_echo_done      (result_ch.echo_done),
        .result_capture_pending(result_ch.capture_pending),
        .result_capture_length (result_ch.capture_length),
        .mismatch_count        (mismatch_count),
        .replies_due_count     (replies_due_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // one bus event request; returns at the falling edge after it is taken
    task automatic send_event(input int mode, input int addr, input int data, input int idx);
        while (gaps_on && $urandom_range(99) < 19)
        begin
            event_ch.valid <= 1'b0;
            @(negedge clk);
        end
        event_ch.valid       <= 1'b1;
        event_ch.mode        <= 3'(mode);
        event_ch.bus_address <= 7'(addr);
        event_ch.write_byte  <= 8'(data);
        event_ch.fetch_index <= 5'(idx);
        if (mode <= MODE_STOP || mode == MODE_FETCH)
            counted_events++;
        @(posedge clk);
        while (!event_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_mode(input int mode);
        send_event(mode, $urandom_range(127), $urandom_range(255), $urandom_range(31));
    endtask

    task automatic send_address_event();
        send_event(MODE_ADDRESSED, ($urandom_range(99) < 85) ? target_address
                   : $urandom_range(127), $urandom_range(255), $urandom_range(31));
    endtask

    // write phase, repeated start, read back, stop, then fetches of the capture
    task automatic echo_session();
        int n_wr;
        int n_rd;
        n_wr = ($urandom_range(9) == 0) ? $urandom_range(BUFFER_DEPTH + 2, BUFFER_DEPTH - 4)
               : $urandom_range(6, 1);
        send_address_event();
        repeat (n_wr)
            send_mode(MODE_WRITE);
        send_address_event();
        n_rd = $urandom_range(n_wr + 2);
        repeat (n_rd)
            send_mode(MODE_READ);
        send_mode(MODE_STOP);
        repeat ($urandom_range(3))
            send_event(MODE_FETCH, $urandom_range(127), $urandom_range(255),
                       $urandom_range(1) ? $urandom_range(7) : $urandom_range(31));
    endtask

    task automatic broken_sequence();
        repeat ($urandom_range(8, 1))
            send_mode(($urandom_range(9) == 0) ? MODE_FETCH : $urandom_range(3));
    endtask

    task automatic write_own_address(input logic [6:0] addr);
        cfg_we         <= 1'b1;
        cfg_wdata      <= addr;
        target_address  = addr;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_replies();
        event_ch.valid <= 1'b0;
        while (replies_due_count != 0)
            @(negedge clk);
    endtask

    // reply side backpressure
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= !gaps_on || ($urandom_range(99) >= 19);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((event_ch.valid && event_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_i2c_target_echo_buffer failed");
        $finish;
    end

    initial
    begin
        int goal;
        int pick;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        gaps_on              = 1'b1;
        target_address       = OWN_ADDRESS_RST;
        counted_events       = 0;
        event_ch.valid       = 1'b0;
        event_ch.mode        = MODE_ADDRESSED;
        event_ch.bus_address = '0;
        event_ch.write_byte  = '0;
        event_ch.fetch_index = '0;
        repeat (6)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: full echo round trip, then the corner cases
        send_event(MODE_ADDRESSED, target_address, 8'h00, 5'd0);
        send_event(MODE_WRITE, 7'd0, 8'h00, 5'd0);
        send_event(MODE_WRITE, 7'd127, 8'hFF, 5'd31);
        send_event(MODE_WRITE, 7'd0, 8'h5A, 5'd0);
        send_event(MODE_ADDRESSED, 7'd0, 8'h00, 5'd0);      // mismatch still swaps
        send_event(MODE_READ, 7'd0, 8'h00, 5'd0);
        send_event(MODE_READ, 7'd0, 8'h00, 5'd0);
        send_event(MODE_READ, 7'd0, 8'h00, 5'd0);
        send_event(MODE_READ, 7'd0, 8'h00, 5'd0);           // nothing left to send
        send_event(MODE_STOP, 7'd0, 8'h00, 5'd0);
        send_event(MODE_FETCH, 7'd0, 8'h00, 5'd1);
        send_event(MODE_FETCH, 7'd0, 8'h00, 5'd31);         // past the capture
        send_event(MODE_FETCH, 7'd127, 8'hFF, 5'd2);
        send_event(MODE_ERROR, 7'd127, 8'hFF, 5'd31);
        send_event(MODE_SPARE_6, 7'd127, 8'hFF, 5'd31);
        send_event(MODE_SPARE_7, 7'd127, 8'hFF, 5'd31);
        send_event(MODE_STOP, 7'd0, 8'h00, 5'd0);           // stop with nothing read
        send_event(MODE_ADDRESSED, 7'd127, 8'h00, 5'd0);
        send_event(MODE_WRITE, 7'd0, 8'h81, 5'd0);
        send_event(MODE_WRITE, 7'd0, 8'h7E, 5'd0);
        send_event(MODE_STOP, 7'd0, 8'h00, 5'd0);           // write then stop
        send_event(MODE_ADDRESSED, target_address, 8'h00, 5'd0);
        send_event(MODE_READ, 7'd0, 8'h00, 5'd0);
        send_event(MODE_FETCH, 7'd0, 8'h00, 5'd0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_replies();
            case (phase)
                0:       write_own_address(7'd0);
                1:       write_own_address(7'd127);
                2:       write_own_address(7'($urandom_range(127)));
                default: write_own_address(OWN_ADDRESS_RST);
            endcase
            // second phase runs with no gaps on either side
            gaps_on = (phase != 1);
            goal = counted_events + RANDOM_EVENTS / PHASES;
            while (counted_events < goal)
            begin
                pick = $urandom_range(99);
                if (pick < 65)
                    echo_session();
                else if (pick < 85)
                    broken_sequence();
                else
                    send_mode($urandom_range(7));
            end
        end

        drain_replies();
        repeat (4)
            @(negedge clk);
        if (mismatch_count == 0 && replies_due_count == 0)
            $display("tb_i2c_target_echo_buffer passed");
        else
            $display("tb_i2c_target_echo_buffer failed");
        $finish;
    end

endmodule
